FILE: rtl/core/quaternion_to_rotation_matrix_core_assert.svh
// Assertion helpers for the core top file.
`ifndef QUATERNION_TO_ROTATION_MATRIX_CORE_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_CORE_ASSERT_SVH

// Condition must hold on every clock edge out of reset.
`define Q2R_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define Q2R_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/q2r_pkg.sv
package q2r_pkg;

	localparam int COMP_WIDTH = 16;
	localparam int CW = COMP_WIDTH;
	localparam int FRAC_BITS = CW - 2;
	localparam bit IN_DROP = (CW > 31);
	localparam int PW = 2 * CW;          // product width
	localparam int NW = 2 * CW + 1;      // norm width
	localparam int AW = 2 * CW + 2;      // numerator magnitude width
	localparam int SW = 2 * CW + 3;      // signed numerator width
	localparam int QB = FRAC_BITS + 3;   // quotient bits
	localparam int EW = CW + 2;          // signed entry width before saturation
	localparam int NUM_E = 9;

	typedef logic signed [CW-1:0] comp_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic [NW-1:0] nrm_t;
	typedef logic [AW-1:0] num_t;
	typedef logic [QB-1:0] quo_t;

	typedef struct packed {
		logic             zero;
		logic [NUM_E-1:0] neg;
	} side_t;

	localparam comp_t ONE_E = comp_t'(64'sd1 <<< FRAC_BITS);
	localparam comp_t NEG_ONE_E = -ONE_E;
	localparam comp_t MAX_E = comp_t'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam comp_t MIN_E = -MAX_E - comp_t'(1);

	// Halve toward zero at the widest setting so the sums fit.
	function automatic comp_t in_drop(input comp_t v);
		logic signed [CW:0] t;
		t = {v[CW-1], v} + {{CW{1'b0}}, v[CW-1]};
		if (IN_DROP)
			return comp_t'(t[CW:1]);
		else
			return v;
	endfunction

	function automatic comp_t sat(input logic signed [EW-1:0] v);
		if (v > EW'(MAX_E))
			return MAX_E;
		else if (v < EW'(MIN_E))
			return MIN_E;
		else
			return comp_t'(v[CW-1:0]);
	endfunction

endpackage

FILE: rtl/core/q2r_div.sv
// Restoring divider, one quotient bit per stage: floor(a * 2^(F+1) / n).
module q2r_div import q2r_pkg::*; (
	input  logic clk,
	input  logic adv,
	input  num_t a,
	input  nrm_t n,
	output quo_t q
);

	num_t r_s [QB];
	quo_t q_s [QB];
	nrm_t n_s [QB];

	for (genvar i = 0; i < QB; i++) begin : g_stage
		num_t rin, d, rout;
		quo_t qin;
		nrm_t nin;
		logic ge;

		if (i == 0) begin : g_first
			assign rin = a;
			assign d = {n, 1'b0};
			assign qin = '0;
			assign nin = n;
		end else if (i == 1) begin : g_int
			assign rin = r_s[i-1];
			assign d = {1'b0, n_s[i-1]};
			assign qin = q_s[i-1];
			assign nin = n_s[i-1];
		end else begin : g_frac
			assign rin = {r_s[i-1][AW-2:0], 1'b0};
			assign d = {1'b0, n_s[i-1]};
			assign qin = q_s[i-1];
			assign nin = n_s[i-1];
		end

		assign ge = (rin >= d);
		assign rout = ge ? rin - d : rin;

		always_ff @(posedge clk) begin
			if (adv) begin
				r_s[i] <= rout;
				q_s[i] <= {qin[QB-2:0], ge};
				n_s[i] <= nin;
			end
		end
	end

	assign q = q_s[QB-1];

endmodule

FILE: rtl/core/quaternion_to_rotation_matrix_core.sv
// Pipeline: input register, products, numerators and norm, then the bit-per-stage
// restoring dividers, one per matrix entry, then the output register.
// Throughput: one quaternion per cycle; a stall at the output holds every stage.
// Reset clears only the valid bits; data registers are not reset.
`include "quaternion_to_rotation_matrix_core_assert.svh"
module quaternion_to_rotation_matrix_core import q2r_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  comp_t quat_w,
	input  comp_t quat_x,
	input  comp_t quat_y,
	input  comp_t quat_z,
	output logic  out_valid,
	input  logic  out_ready,
	output comp_t e_c0r0,
	output comp_t e_c1r0,
	output comp_t e_c2r0,
	output comp_t e_c0r1,
	output comp_t e_c1r1,
	output comp_t e_c2r1,
	output comp_t e_c0r2,
	output comp_t e_c1r2,
	output comp_t e_c2r2,
	output logic  zero_norm
);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;
	logic [QB-1:0] vd_s;
	comp_t w_s1, x_s1, y_s1, z_s1;
	prod_t ww_s2, xx_s2, yy_s2, zz_s2, xy_s2, xz_s2, yz_s2, xw_s2, yw_s2, zw_s2;
	nrm_t n_s3;
	num_t a_s3 [NUM_E];
	side_t side_s3;
	side_t sd_s [QB];
	quo_t q_d [NUM_E];
	comp_t e_s4 [NUM_E];
	logic zn_s4;

	logic signed [SW-1:0] num [NUM_E];
	logic [NW-1:0] n_c;
	side_t side_c;
	comp_t e_c [NUM_E];

	assign adv = !v_s4 || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			vd_s <= '0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			vd_s <= {vd_s[QB-2:0], v_s3};
			v_s4 <= vd_s[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1 <= in_drop(quat_w);
			x_s1 <= in_drop(quat_x);
			y_s1 <= in_drop(quat_y);
			z_s1 <= in_drop(quat_z);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ww_s2 <= PW'(w_s1) * PW'(w_s1);
			xx_s2 <= PW'(x_s1) * PW'(x_s1);
			yy_s2 <= PW'(y_s1) * PW'(y_s1);
			zz_s2 <= PW'(z_s1) * PW'(z_s1);
			xy_s2 <= PW'(x_s1) * PW'(y_s1);
			xz_s2 <= PW'(x_s1) * PW'(z_s1);
			yz_s2 <= PW'(y_s1) * PW'(z_s1);
			xw_s2 <= PW'(x_s1) * PW'(w_s1);
			yw_s2 <= PW'(y_s1) * PW'(w_s1);
			zw_s2 <= PW'(z_s1) * PW'(w_s1);
		end
	end

	// Numerators 2*(p +/- q), in row-major entry order.
	always_comb begin
		num[0] = (SW'(yy_s2) + SW'(zz_s2)) <<< 1;
		num[1] = (SW'(xy_s2) - SW'(zw_s2)) <<< 1;
		num[2] = (SW'(xz_s2) + SW'(yw_s2)) <<< 1;
		num[3] = (SW'(xy_s2) + SW'(zw_s2)) <<< 1;
		num[4] = (SW'(xx_s2) + SW'(zz_s2)) <<< 1;
		num[5] = (SW'(yz_s2) - SW'(xw_s2)) <<< 1;
		num[6] = (SW'(xz_s2) - SW'(yw_s2)) <<< 1;
		num[7] = (SW'(yz_s2) + SW'(xw_s2)) <<< 1;
		num[8] = (SW'(xx_s2) + SW'(yy_s2)) <<< 1;
		n_c = NW'(ww_s2) + NW'(xx_s2) + NW'(yy_s2) + NW'(zz_s2);
		side_c.zero = (n_c == '0);
		for (int k = 0; k < NUM_E; k++)
			side_c.neg[k] = num[k][SW-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s3 <= n_c;
			side_s3 <= side_c;
			for (int k = 0; k < NUM_E; k++)
				a_s3[k] <= num_t'(num[k][SW-1] ? -num[k] : num[k]);
		end
	end

	for (genvar k = 0; k < NUM_E; k++) begin : g_lane
		q2r_div u_div (
			.clk (clk),
			.adv (adv),
			.a   (a_s3[k]),
			.n   (n_s3),
			.q   (q_d[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s[0] <= side_s3;
			for (int i = 1; i < QB; i++)
				sd_s[i] <= sd_s[i-1];
		end
	end

	// Round half away from zero, restore sign, subtract diagonal terms from one, saturate; a zero norm gives identity.
	always_comb begin
		for (int k = 0; k < NUM_E; k++) begin
			logic [QB:0] qp;
			logic signed [EW-1:0] sm;
			qp = {1'b0, q_d[k]} + (QB+1)'(1);
			sm = EW'({1'b0, qp[QB:1]});
			if (sd_s[QB-1].neg[k])
				sm = -sm;
			if (k == 0 || k == 4 || k == 8) begin
				sm = EW'(ONE_E) - sm;
				e_c[k] = sd_s[QB-1].zero ? ONE_E : sat(sm);
			end else begin
				e_c[k] = sd_s[QB-1].zero ? '0 : sat(sm);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zn_s4 <= sd_s[QB-1].zero;
			for (int k = 0; k < NUM_E; k++)
				e_s4[k] <= e_c[k];
		end
	end

	assign out_valid = v_s4;
	assign zero_norm = zn_s4;
	assign e_c0r0 = e_s4[0];
	assign e_c1r0 = e_s4[1];
	assign e_c2r0 = e_s4[2];
	assign e_c0r1 = e_s4[3];
	assign e_c1r1 = e_s4[4];
	assign e_c2r1 = e_s4[5];
	assign e_c0r2 = e_s4[6];
	assign e_c1r2 = e_s4[7];
	assign e_c2r2 = e_s4[8];

	`Q2R_ASSERT(a_zero_ident, !(out_valid && zero_norm) || (e_c0r0 == ONE_E && e_c1r1 == ONE_E && e_c2r2 == ONE_E && e_c1r0 == '0 && e_c2r0 == '0 && e_c0r1 == '0 && e_c2r1 == '0 && e_c0r2 == '0 && e_c1r2 == '0), "zero quaternion must give identity")
	`Q2R_ASSERT(a_diag_range, !out_valid || (e_c0r0 >= NEG_ONE_E && e_c0r0 <= ONE_E && e_c1r1 >= NEG_ONE_E && e_c1r1 <= ONE_E && e_c2r2 >= NEG_ONE_E && e_c2r2 <= ONE_E), "diagonal entry out of unit range")
	`Q2R_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(e_c1r0) && $stable(zero_norm) && $stable(vd_s), "pipeline moved during output stall")

endmodule
